// ----- hdl/lbr_pkg.sv -----
package lbr_pkg;

	// Frame store geometry.
	localparam int MAX_WIDTH = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int MAX_CHANNELS = 3;
	localparam int PLANE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int STORE_DEPTH = MAX_CHANNELS * PLANE_SIZE;
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	// Field widths.
	localparam int PIX_W = 16;
	localparam int POS_W = 10;
	localparam int CH_W = 2;
	localparam int SDIM_W = 10;
	localparam int DDIM_W = 11;
	localparam int FRAC_W = 16;
	localparam int PROD_W = SDIM_W + DDIM_W;
	localparam int NUM_W = POS_W + SDIM_W;

	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LETTERBOX_ON = 3'd5;

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Divider: four quotient bits per cycle.
	localparam int DVD_W = NUM_W + FRAC_W;
	localparam int DVS_W = DDIM_W;
	localparam int DIV_BITS = 4;
	localparam int DIV_STEPS = DVD_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [PIX_W-1:0] GRAY_HALF = 16'h8000;
	localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_LOAD = 2'd0;
	localparam kind_t KIND_QUERY = 2'd1;
	localparam kind_t KIND_OOR = 2'd2;

	typedef struct packed {
		kind_t kind;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [CH_W-1:0] ch;
		logic [PIX_W-1:0] pix;
	} item_t;

	typedef struct packed {
		logic [SDIM_W-1:0] sw;
		logic [SDIM_W-1:0] sh;
		logic [CH_W-1:0] nch;
		logic [DDIM_W-1:0] dw;
		logic [DDIM_W-1:0] dh;
		logic lb;
	} cfg_t;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [CH_W-1:0] ch,
			input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
		return ADDR_W'(int'(ch) * PLANE_SIZE + int'(y) * MAX_WIDTH + int'(x));
	endfunction

endpackage

// ----- hdl/lbr_div.sv -----
module lbr_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [lbr_pkg::DVD_W-1:0] dividend,
	input logic [lbr_pkg::DVS_W-1:0] divisor,
	output logic done,
	output logic [lbr_pkg::DVD_W-1:0] quotient
);

	logic busy_q;
	logic done_q;
	logic [lbr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [lbr_pkg::DVS_W:0] rem_q;
	logic [lbr_pkg::DVD_W-1:0] quo_q;
	logic [lbr_pkg::DVS_W-1:0] dvs_q;
	logic [lbr_pkg::DVS_W:0] rem_nx;
	logic [lbr_pkg::DVD_W-1:0] quo_nx;

	// Restoring division; the dividend shifts out of quo_q as quotient bits shift in.
	always_comb begin
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int i = 0; i < lbr_pkg::DIV_BITS; i++) begin
			rem_nx = {rem_nx[lbr_pkg::DVS_W-1:0], quo_nx[lbr_pkg::DVD_W-1]};
			quo_nx = {quo_nx[lbr_pkg::DVD_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, dvs_q}) begin
				rem_nx = rem_nx - {1'b0, dvs_q};
				quo_nx[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q
				&& (cnt_q == lbr_pkg::DIV_CNT_W'(lbr_pkg::DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lbr_pkg::DIV_CNT_W'(lbr_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ----- hdl/lbr_front.sv -----
module lbr_front (
	input logic clk,
	input logic arst_n,
	input lbr_pkg::cfg_t cfg,
	input logic push,
	output logic full,
	input logic req_type,
	input logic [lbr_pkg::POS_W-1:0] pos_x,
	input logic [lbr_pkg::POS_W-1:0] pos_y,
	input logic [lbr_pkg::CH_W-1:0] chan,
	input logic [lbr_pkg::PIX_W-1:0] pixel_in,
	output logic q_valid,
	output lbr_pkg::item_t q_item,
	input logic q_pop
);

	lbr_pkg::item_t qmem [lbr_pkg::QDEPTH];
	logic [lbr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lbr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lbr_pkg::QCNT_W-1:0] cnt_q;
	logic load_ok;
	logic query_oor;
	logic enq;
	logic deq;
	lbr_pkg::item_t item_in;

	// Loads outside the current source are dropped here and never reach the back.
	assign load_ok = (pos_x < cfg.sw) && (pos_y < cfg.sh) && (chan < cfg.nch);
	assign query_oor = ({1'b0, pos_x} >= cfg.dw) || ({1'b0, pos_y} >= cfg.dh)
		|| (chan >= cfg.nch);

	always_comb begin
		item_in.x = pos_x;
		item_in.y = pos_y;
		item_in.ch = chan;
		item_in.pix = pixel_in;
		if (!req_type) begin
			item_in.kind = lbr_pkg::KIND_LOAD;
		end else if (query_oor) begin
			item_in.kind = lbr_pkg::KIND_OOR;
		end else begin
			item_in.kind = lbr_pkg::KIND_QUERY;
		end
	end

	assign full = (cnt_q == lbr_pkg::QCNT_W'(lbr_pkg::QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item = qmem[rd_ptr_q];
	assign enq = push && !full && (req_type || load_ok);
	assign deq = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == lbr_pkg::QPTR_W'(lbr_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == lbr_pkg::QPTR_W'(lbr_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			qmem[wr_ptr_q] <= item_in;
		end
	end

endmodule

// ----- hdl/lbr_back.sv -----
module lbr_back (
	input logic clk,
	input logic arst_n,
	input lbr_pkg::cfg_t cfg,
	input logic q_valid,
	input lbr_pkg::item_t q_item,
	output logic q_pop,
	output logic empty,
	input logic pop,
	output logic [lbr_pkg::PIX_W-1:0] pixel_out,
	output logic in_border,
	output logic out_of_range
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FITMUL = 4'd1;
	localparam logic [3:0] ST_FITSEL = 4'd2;
	localparam logic [3:0] ST_FITDIV = 4'd3;
	localparam logic [3:0] ST_BOX = 4'd4;
	localparam logic [3:0] ST_YMUL = 4'd5;
	localparam logic [3:0] ST_YDIV = 4'd6;
	localparam logic [3:0] ST_XMUL = 4'd7;
	localparam logic [3:0] ST_XDIV = 4'd8;
	localparam logic [3:0] ST_READ = 4'd9;
	localparam logic [3:0] ST_BLEND = 4'd10;
	localparam logic [3:0] ST_OUT = 4'd11;

	logic [3:0] state_q;
	logic div_go_q;
	logic out_valid_q;
	logic [2:0] rstep_q;
	logic [2:0] bstep_q;
	logic phase_q;

	lbr_pkg::item_t item_q;
	logic fit_h_q;
	logic [lbr_pkg::DDIM_W-1:0] fw_q, fh_q;
	logic [lbr_pkg::PROD_W-1:0] prod_a_q, prod_b_q;
	logic [lbr_pkg::POS_W-1:0] lx_q, ly_q;
	logic [lbr_pkg::POS_W-1:0] iy_q, col0_q, col1_q;
	logic [lbr_pkg::FRAC_W-1:0] dx_q, dy_q;
	logic ylast_q;
	logic [lbr_pkg::DVD_W-1:0] dvd_q;
	logic [lbr_pkg::DVS_W-1:0] dvs_q;
	logic [lbr_pkg::PIX_W-1:0] pix_q [4];
	logic [lbr_pkg::PIX_W-1:0] rd_q;
	logic [lbr_pkg::PIX_W-1:0] r0_q, r1_q;
	logic [lbr_pkg::PIX_W+lbr_pkg::FRAC_W:0] mul_q;
	logic [lbr_pkg::PIX_W+lbr_pkg::FRAC_W+1:0] acc_q;
	logic [lbr_pkg::PIX_W-1:0] res_pix_q;
	logic res_border_q, res_oor_q;
	logic [lbr_pkg::PIX_W-1:0] out_pix_q;
	logic out_border_q, out_oor_q;

	logic [lbr_pkg::PIX_W-1:0] store [lbr_pkg::STORE_DEPTH];
	logic [lbr_pkg::ADDR_W-1:0] mem_addr;
	logic mem_we;

	logic div_done;
	logic [lbr_pkg::DVD_W-1:0] div_quo;

	logic out_free;
	logic [lbr_pkg::DDIM_W-1:0] ox, oy;
	logic [lbr_pkg::DDIM_W:0] px_e, py_e, lx_e, ly_e;
	logic border;
	logic [lbr_pkg::NUM_W-1:0] ymul, xmul;
	logic [lbr_pkg::POS_W-1:0] qidx, iy_cl, row1;
	logic xlast, ylast;
	logic [lbr_pkg::FRAC_W:0] wsel;
	logic [lbr_pkg::FRAC_W-1:0] wraw;
	logic [lbr_pkg::PIX_W-1:0] vsel;
	logic [lbr_pkg::PIX_W+lbr_pkg::FRAC_W+1:0] sum;

	lbr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_go_q),
		.dividend(dvd_q),
		.divisor(dvs_q),
		.done(div_done),
		.quotient(div_quo)
	);

	assign out_free = !out_valid_q || pop;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign mem_we = q_pop && (q_item.kind == lbr_pkg::KIND_LOAD);

	// Centering offsets and the border test of the fitted area.
	assign ox = (cfg.dw - fw_q) >> 1;
	assign oy = (cfg.dh - fh_q) >> 1;
	assign px_e = {2'b0, item_q.x};
	assign py_e = {2'b0, item_q.y};
	assign lx_e = px_e - {1'b0, ox};
	assign ly_e = py_e - {1'b0, oy};
	assign border = (px_e < {1'b0, ox}) || (py_e < {1'b0, oy})
		|| (lx_e >= {1'b0, fw_q}) || (ly_e >= {1'b0, fh_q});

	assign ymul = lbr_pkg::NUM_W'(ly_q) * lbr_pkg::NUM_W'(cfg.sh - 1'b1);
	assign xmul = lbr_pkg::NUM_W'(lx_q) * lbr_pkg::NUM_W'(cfg.sw - 1'b1);
	assign qidx = div_quo[lbr_pkg::FRAC_W +: lbr_pkg::POS_W];
	assign iy_cl = (qidx >= cfg.sh) ? cfg.sh - 1'b1 : qidx;

	assign xlast = ({1'b0, lx_q} == fw_q - 1'b1) || (cfg.sw == lbr_pkg::SDIM_W'(1));
	assign ylast = ({1'b0, ly_q} == fh_q - 1'b1) || (cfg.sh == lbr_pkg::SDIM_W'(1))
		|| ({1'b0, iy_q} + 1'b1 >= {1'b0, cfg.sh});
	assign row1 = ylast_q ? iy_q : iy_q + 1'b1;

	always_comb begin
		case (rstep_q)
			3'd0: mem_addr = lbr_pkg::addr_of(item_q.ch, col0_q, iy_q);
			3'd1: mem_addr = lbr_pkg::addr_of(item_q.ch, col1_q, iy_q);
			3'd2: mem_addr = lbr_pkg::addr_of(item_q.ch, col0_q, row1);
			default: mem_addr = lbr_pkg::addr_of(item_q.ch, col1_q, row1);
		endcase
		if (state_q == ST_IDLE) begin
			mem_addr = lbr_pkg::addr_of(q_item.ch, q_item.x, q_item.y);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[mem_addr] <= q_item.pix;
		end
		rd_q <= store[mem_addr];
	end

	// Blend operands: even steps take the left or upper weight, odd steps the other.
	always_comb begin
		wraw = (bstep_q < 3'd4) ? dx_q : dy_q;
		wsel = bstep_q[0] ? {1'b0, wraw} : lbr_pkg::ONE_Q16 - {1'b0, wraw};
		case (bstep_q)
			3'd0: vsel = pix_q[0];
			3'd1: vsel = pix_q[1];
			3'd2: vsel = pix_q[2];
			3'd3: vsel = pix_q[3];
			3'd4: vsel = r0_q;
			default: vsel = r1_q;
		endcase
		sum = (bstep_q[0] ? acc_q : '0) + {1'b0, mul_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_go_q <= 1'b0;
			out_valid_q <= 1'b0;
			rstep_q <= '0;
			bstep_q <= '0;
			phase_q <= 1'b0;
		end else begin
			// The divider starts for the fit, the row map or the column map when needed.
			div_go_q <= ((state_q == ST_FITSEL) && cfg.lb)
				|| ((state_q == ST_YMUL) && (fh_q > lbr_pkg::DDIM_W'(1)))
				|| ((state_q == ST_XMUL) && !xlast);
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.kind == lbr_pkg::KIND_QUERY) begin
							state_q <= ST_FITMUL;
						end else if (q_item.kind == lbr_pkg::KIND_OOR) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_FITMUL: state_q <= ST_FITSEL;
				ST_FITSEL: begin
					if (cfg.lb) begin
						state_q <= ST_FITDIV;
					end else begin
						state_q <= ST_BOX;
					end
				end
				ST_FITDIV: begin
					if (div_done) begin
						state_q <= ST_BOX;
					end
				end
				ST_BOX: state_q <= border ? ST_OUT : ST_YMUL;
				ST_YMUL: begin
					if (fh_q > lbr_pkg::DDIM_W'(1)) begin
						state_q <= ST_YDIV;
					end else begin
						state_q <= ST_XMUL;
					end
				end
				ST_YDIV: begin
					if (div_done) begin
						state_q <= ST_XMUL;
					end
				end
				ST_XMUL: begin
					rstep_q <= '0;
					if (xlast) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_XDIV;
					end
				end
				ST_XDIV: begin
					if (div_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rstep_q <= rstep_q + 1'b1;
					if (rstep_q == 3'd4) begin
						bstep_q <= '0;
						phase_q <= 1'b0;
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						bstep_q <= bstep_q + 1'b1;
						if (bstep_q == 3'd5) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= q_item;
				res_pix_q <= '0;
				res_border_q <= 1'b0;
				res_oor_q <= 1'b1;
			end
			ST_FITMUL: begin
				prod_a_q <= lbr_pkg::PROD_W'(cfg.dw) * lbr_pkg::PROD_W'(cfg.sh);
				prod_b_q <= lbr_pkg::PROD_W'(cfg.dh) * lbr_pkg::PROD_W'(cfg.sw);
			end
			ST_FITSEL: begin
				fw_q <= cfg.dw;
				fh_q <= cfg.dh;
				fit_h_q <= prod_a_q < prod_b_q;
				if (prod_a_q < prod_b_q) begin
					dvd_q <= lbr_pkg::DVD_W'(prod_a_q);
					dvs_q <= lbr_pkg::DVS_W'(cfg.sw);
				end else begin
					dvd_q <= lbr_pkg::DVD_W'(prod_b_q);
					dvs_q <= lbr_pkg::DVS_W'(cfg.sh);
				end
			end
			ST_FITDIV: begin
				if (div_done) begin
					if (fit_h_q) begin
						fh_q <= div_quo[lbr_pkg::DDIM_W-1:0];
					end else begin
						fw_q <= div_quo[lbr_pkg::DDIM_W-1:0];
					end
				end
			end
			ST_BOX: begin
				lx_q <= lx_e[lbr_pkg::POS_W-1:0];
				ly_q <= ly_e[lbr_pkg::POS_W-1:0];
				res_pix_q <= lbr_pkg::GRAY_HALF;
				res_border_q <= 1'b1;
				res_oor_q <= 1'b0;
			end
			ST_YMUL: begin
				iy_q <= '0;
				dy_q <= '0;
				dvd_q <= {ymul, lbr_pkg::FRAC_W'(0)};
				dvs_q <= fh_q - 1'b1;
			end
			ST_YDIV: begin
				if (div_done) begin
					iy_q <= iy_cl;
					dy_q <= div_quo[lbr_pkg::FRAC_W-1:0];
				end
			end
			ST_XMUL: begin
				ylast_q <= ylast;
				col0_q <= lbr_pkg::POS_W'(cfg.sw - 1'b1);
				col1_q <= lbr_pkg::POS_W'(cfg.sw - 1'b1);
				dx_q <= '0;
				dvd_q <= {xmul, lbr_pkg::FRAC_W'(0)};
				dvs_q <= fw_q - 1'b1;
			end
			ST_XDIV: begin
				if (div_done) begin
					col0_q <= qidx;
					col1_q <= qidx + 1'b1;
					dx_q <= div_quo[lbr_pkg::FRAC_W-1:0];
				end
			end
			ST_READ: begin
				if (rstep_q != 3'd0) begin
					pix_q[rstep_q[1:0] - 2'd1] <= rd_q;
				end
			end
			ST_BLEND: begin
				if (!phase_q) begin
					mul_q <= wsel * vsel;
				end else begin
					acc_q <= sum;
					if (bstep_q == 3'd1) begin
						r0_q <= sum[lbr_pkg::FRAC_W +: lbr_pkg::PIX_W];
					end
					if (bstep_q == 3'd3) begin
						r1_q <= ylast_q ? '0 : sum[lbr_pkg::FRAC_W +: lbr_pkg::PIX_W];
					end
					if (bstep_q == 3'd5) begin
						res_pix_q <= (|sum[$high(sum):lbr_pkg::FRAC_W+lbr_pkg::PIX_W]) ? '1
							: sum[lbr_pkg::FRAC_W +: lbr_pkg::PIX_W];
						res_border_q <= 1'b0;
						res_oor_q <= 1'b0;
					end
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_pix_q <= res_pix_q;
					out_border_q <= res_border_q;
					out_oor_q <= res_oor_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign empty = !out_valid_q;
	assign pixel_out = out_pix_q;
	assign in_border = out_border_q;
	assign out_of_range = out_oor_q;

endmodule

// ----- hdl/letterbox_bilinear_resize.sv -----
// Letterbox bilinear resize. Items enter through a queue-like port (push/full)
// and are either loads of one source pixel into the on-chip planar frame store
// or queries for one destination pixel. Each query gives exactly one result item,
// in order, on the result side (empty/pop); loads give none, and loads outside the
// configured source are dropped. Results are align-corners bilinear in unsigned
// Q0.16; in letterbox mode border pixels read 0.5 with in_border set, and queries
// outside the destination or channel count read 0 with out_of_range set.
// A load is written to the store when the back takes it from the queue. An
// out-of-range query skips all computation, and a border query ends at the box
// test, after the fit division in letterbox mode. An interior query's time is set
// by the shared divider, which yields four quotient bits per cycle and runs up to
// three divisions per query (the fit, the row map and the column map), by four
// reads of the single-port frame store, and by six passes through one multiplier.
// Configuration may be written only while the block is idle; the store is not
// cleared at reset, so pixels must be loaded before they are queried.
module letterbox_bilinear_resize (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic req_type,
	input logic [lbr_pkg::POS_W-1:0] pos_x,
	input logic [lbr_pkg::POS_W-1:0] pos_y,
	input logic [lbr_pkg::CH_W-1:0] chan,
	input logic [lbr_pkg::PIX_W-1:0] pixel_in,
	output logic empty,
	input logic pop,
	output logic [lbr_pkg::PIX_W-1:0] pixel_out,
	output logic in_border,
	output logic out_of_range,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lbr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lbr_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [lbr_pkg::SDIM_W-1:0] src_width_q, src_height_q;
	logic [lbr_pkg::DDIM_W-1:0] dst_width_q, dst_height_q;
	logic [lbr_pkg::CH_W-1:0] num_channels_q;
	logic letterbox_on_q;
	lbr_pkg::cfg_t cfg;
	logic q_valid, q_pop;
	lbr_pkg::item_t q_item;

	// The register file is always ready; writes to unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= lbr_pkg::SDIM_W'(1);
			src_height_q <= lbr_pkg::SDIM_W'(1);
			dst_width_q <= lbr_pkg::DDIM_W'(1);
			dst_height_q <= lbr_pkg::DDIM_W'(1);
			num_channels_q <= lbr_pkg::CH_W'(3);
			letterbox_on_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lbr_pkg::REG_SRC_WIDTH: src_width_q <= cfg_data[lbr_pkg::SDIM_W-1:0];
				lbr_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data[lbr_pkg::SDIM_W-1:0];
				lbr_pkg::REG_DST_WIDTH: dst_width_q <= cfg_data;
				lbr_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_data;
				lbr_pkg::REG_NUM_CHANNELS: num_channels_q <= cfg_data[lbr_pkg::CH_W-1:0];
				lbr_pkg::REG_LETTERBOX_ON: letterbox_on_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Effective source sizes and channel count: a zero is taken as one, and values beyond the store are capped.
	always_comb begin
		if (src_width_q == '0) begin
			cfg.sw = lbr_pkg::SDIM_W'(1);
		end else if (int'(src_width_q) > lbr_pkg::MAX_WIDTH) begin
			cfg.sw = lbr_pkg::SDIM_W'(lbr_pkg::MAX_WIDTH);
		end else begin
			cfg.sw = src_width_q;
		end
		if (src_height_q == '0) begin
			cfg.sh = lbr_pkg::SDIM_W'(1);
		end else if (int'(src_height_q) > lbr_pkg::MAX_HEIGHT) begin
			cfg.sh = lbr_pkg::SDIM_W'(lbr_pkg::MAX_HEIGHT);
		end else begin
			cfg.sh = src_height_q;
		end
		if (num_channels_q == '0) begin
			cfg.nch = lbr_pkg::CH_W'(1);
		end else if (int'(num_channels_q) > lbr_pkg::MAX_CHANNELS) begin
			cfg.nch = lbr_pkg::CH_W'(lbr_pkg::MAX_CHANNELS);
		end else begin
			cfg.nch = num_channels_q;
		end
		cfg.dw = dst_width_q;
		cfg.dh = dst_height_q;
		cfg.lb = letterbox_on_q;
	end

	// The front classifies and queues items; the back computes and stores pixels.
	lbr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.push(push),
		.full(full),
		.req_type(req_type),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.chan(chan),
		.pixel_in(pixel_in),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	lbr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.pixel_out(pixel_out),
		.in_border(in_border),
		.out_of_range(out_of_range)
	);

endmodule

// ----- tb/sv/letterbox_bilinear_resize_checker.sv -----
module letterbox_bilinear_resize_checker
	import lbr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic req_type,
	input logic [POS_W-1:0] pos_x,
	input logic [POS_W-1:0] pos_y,
	input logic [CH_W-1:0] chan,
	input logic [PIX_W-1:0] pixel_in,
	input logic empty,
	input logic pop,
	input logic [PIX_W-1:0] pixel_out,
	input logic in_border,
	input logic out_of_range,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output int pending,
	output int errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic border;
		logic oor;
	} pixel_result_t;

	// Shadow copy of the frame store and of the registers.
	logic [PIX_W-1:0] frame [int];
	int unsigned src_w, src_h, dst_w, dst_h, planes, boxed;
	pixel_result_t expected_pixels [$];

	assign pending = expected_pixels.size();

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_v, got_v);
		errors++;
	endtask

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned sample(input int unsigned ch, input int unsigned x,
			input int unsigned y);
		int key;
		key = ch * PLANE_SIZE + y * MAX_WIDTH + x;
		return frame.exists(key) ? frame[key] : 0;
	endfunction

	function automatic void map_axis(input int unsigned p, input int unsigned s,
			input int unsigned f, output int unsigned idx, output int unsigned wt);
		longint unsigned num;
		if (f <= 1) begin
			idx = 0;
			wt = 0;
			return;
		end
		num = longint'(p) * (s - 1);
		idx = 32'(num / (f - 1));
		wt = 32'(((num % (f - 1)) << 16) / (f - 1));
	endfunction

	function automatic int unsigned mix(input int unsigned a, input int unsigned b,
			input int unsigned w);
		longint unsigned v;
		v = longint'(65536 - w) * a + longint'(w) * b;
		return 32'(v >> 16);
	endfunction

	// Horizontal pass over one source row at fitted column c.
	function automatic int unsigned row_pass(input int unsigned ch, input int unsigned r,
			input int unsigned c, input int unsigned sw, input int unsigned fw);
		int unsigned ix, dx;
		if (c == fw - 1 || sw == 1) return sample(ch, sw - 1, r);
		map_axis(c, sw, fw, ix, dx);
		return mix(sample(ch, ix, r), sample(ch, ix + 1, r), dx);
	endfunction

	function automatic pixel_result_t resize_pixel(input int unsigned px,
			input int unsigned py, input int unsigned ch);
		pixel_result_t res;
		int unsigned sw, sh, nch, fw, fh, ox, oy, lx, ly, iy, dy, a, b, val;
		sw = clamp_dim(src_w, MAX_WIDTH);
		sh = clamp_dim(src_h, MAX_HEIGHT);
		nch = clamp_dim(planes, MAX_CHANNELS);
		res = '{pix: '0, border: 1'b0, oor: 1'b0};
		if (px >= dst_w || py >= dst_h || ch >= nch) begin
			res.oor = 1'b1;
			return res;
		end
		if (boxed != 0) begin
			// Fit by cross-multiplication so no division decides the orientation.
			if (longint'(dst_w) * sh < longint'(dst_h) * sw) begin
				fw = dst_w;
				fh = (sh * dst_w) / sw;
			end else begin
				fh = dst_h;
				fw = (sw * dst_h) / sh;
			end
			ox = (dst_w - fw) / 2;
			oy = (dst_h - fh) / 2;
		end else begin
			fw = dst_w;
			fh = dst_h;
			ox = 0;
			oy = 0;
		end
		if (px < ox || py < oy || px - ox >= fw || py - oy >= fh) begin
			res.pix = GRAY_HALF;
			res.border = 1'b1;
			return res;
		end
		lx = px - ox;
		ly = py - oy;
		map_axis(ly, sh, fh, iy, dy);
		if (iy >= sh) iy = sh - 1;
		a = row_pass(ch, iy, lx, sw, fw);
		if (ly == fh - 1 || sh == 1 || iy + 1 >= sh) begin
			val = 32'((longint'(65536 - dy) * a) >> 16);
		end else begin
			b = row_pass(ch, iy + 1, lx, sw, fw);
			val = mix(a, b, dy);
		end
		if (val > 16'hFFFF) val = 16'hFFFF;
		res.pix = PIX_W'(val);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			src_w = 1;
			src_h = 1;
			dst_w = 1;
			dst_h = 1;
			planes = 3;
			boxed = 1;
			expected_pixels.delete();
		end else begin
			if (pop && !empty) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected result item", 0, pixel_out);
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_out !== want.pix)
						report_mismatch("pixel_out", want.pix, pixel_out);
					if (in_border !== want.border)
						report_mismatch("in_border", want.border, in_border);
					if (out_of_range !== want.oor)
						report_mismatch("out_of_range", want.oor, out_of_range);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SRC_WIDTH: src_w = cfg_data & 11'h3FF;
					REG_SRC_HEIGHT: src_h = cfg_data & 11'h3FF;
					REG_DST_WIDTH: dst_w = cfg_data;
					REG_DST_HEIGHT: dst_h = cfg_data;
					REG_NUM_CHANNELS: planes = cfg_data & 11'h3;
					REG_LETTERBOX_ON: boxed = cfg_data & 11'h1;
					default: ;
				endcase
			end
			if (push && !full) begin
				if (req_type == 1'b0) begin
					// Loads outside the configured source are dropped.
					if (pos_x < clamp_dim(src_w, MAX_WIDTH) && pos_y < clamp_dim(src_h, MAX_HEIGHT)
							&& chan < clamp_dim(planes, MAX_CHANNELS))
						frame[chan * PLANE_SIZE + pos_y * MAX_WIDTH + pos_x] = pixel_in;
				end else begin
					expected_pixels.push_back(resize_pixel(pos_x, pos_y, chan));
				end
			end
		end
	end

endmodule

// ----- tb/sv/letterbox_bilinear_resize_tb.sv -----
module letterbox_bilinear_resize_tb;
	import lbr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic LOAD = 1'b0;
	localparam logic QUERY = 1'b1;
	// Loads give no result, so this many cycles let the last ones settle.
	localparam int SETTLE_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic req_type = 1'b0;
	logic [POS_W-1:0] pos_x = '0;
	logic [POS_W-1:0] pos_y = '0;
	logic [CH_W-1:0] chan = '0;
	logic [PIX_W-1:0] pixel_in = '0;
	logic empty;
	logic pop = 1'b0;
	logic [PIX_W-1:0] pixel_out;
	logic in_border;
	logic out_of_range;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int pending;
	int errors;

	// Idle percentages of the sender and the receiver, changed as the run goes on.
	int send_idle = 26;
	int recv_idle = 86;
	// Effective dimensions of the current setup, used to aim the stimulus.
	int eff_sw, eff_sh, eff_nch, cur_dw, cur_dh;
	int items_sent = 0;

	letterbox_bilinear_resize uut (.*);

	letterbox_bilinear_resize_checker checker_i (.*);

	always #1 clk = ~clk;

	// The receiver pops at random, with the stall rate of the current stage.
	always @(posedge clk) pop <= ($urandom_range(99) >= recv_idle);

	// Send one item; push stays high across back-to-back items and is only
	// lowered when the sender decides to idle or when the bench drains.
	task automatic send_item(input logic kind, input int x, input int y, input int ch,
			input int pix);
		if ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= kind;
		pos_x <= POS_W'(x);
		pos_y <= POS_W'(y);
		chan <= CH_W'(ch);
		pixel_in <= PIX_W'(pix);
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		// Idling stages follow the progress of the item stream.
		if (items_sent == 200) begin
			send_idle = 86;
			recv_idle = 26;
		end else if (items_sent == 400) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Wait until every expected result is out and trailing loads have landed.
	task automatic drain;
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int clamp_to(input int v, input int hi);
		return (v < 1) ? 1 : (v > hi) ? hi : v;
	endfunction

	// Reconfigure the idle block, then fill every source pixel in use so no
	// query can touch an entry that was never written.
	task automatic setup_phase(input int sw, input int sh, input int dw, input int dh,
			input int nch, input int lb);
		drain();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_NUM_CHANNELS, nch);
		write_reg(REG_LETTERBOX_ON, lb);
		cfg_valid <= 1'b0;
		eff_sw = clamp_to(sw & 'h3FF, MAX_WIDTH);
		eff_sh = clamp_to(sh & 'h3FF, MAX_HEIGHT);
		eff_nch = clamp_to(nch & 3, MAX_CHANNELS);
		cur_dw = dw;
		cur_dh = dh;
		for (int c = 0; c < eff_nch; c++)
			for (int y = 0; y < eff_sh; y++)
				for (int x = 0; x < eff_sw; x++)
					send_item(LOAD, x, y, c, $urandom_range(16'hFFFF));
	endtask

	// A mix of queries aimed near the destination, overwriting loads and noise.
	task automatic random_traffic(input int n);
		int pick, qx, qy;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				qx = $urandom_range(cur_dw + 1);
				qy = $urandom_range(cur_dh + 1);
				if (qx > 1023) qx = 1023;
				if (qy > 1023) qy = 1023;
				send_item(QUERY, qx, qy, $urandom_range(eff_nch < 3 ? eff_nch : 2),
					$urandom_range(16'hFFFF));
			end else if (pick < 80) begin
				send_item(QUERY, $urandom_range(1023), $urandom_range(1023),
					$urandom_range(3), $urandom_range(16'hFFFF));
			end else if (pick < 92) begin
				send_item(LOAD, $urandom_range(eff_sw - 1), $urandom_range(eff_sh - 1),
					$urandom_range(eff_nch - 1), $urandom_range(16'hFFFF));
			end else begin
				// Loads outside the source must be ignored by the block.
				send_item(LOAD, eff_sw + $urandom_range(1023 - eff_sw), $urandom_range(1023),
					$urandom_range(3), $urandom_range(16'hFFFF));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a 4x3 source boxed into 7x5, so column 6 is border.
		setup_phase(4, 3, 7, 5, 3, 1);
		send_item(QUERY, 0, 0, 0, 0);
		send_item(QUERY, 5, 4, 2, 0);
		send_item(QUERY, 3, 2, 1, 0);
		send_item(QUERY, 2, 1, 0, 0);
		send_item(QUERY, 6, 2, 1, 0);
		send_item(QUERY, 7, 0, 0, 0);
		send_item(QUERY, 0, 5, 0, 0);
		send_item(QUERY, 0, 0, 3, 0);
		send_item(QUERY, 1023, 1023, 0, 16'hFFFF);
		send_item(LOAD, 4, 0, 0, 16'hFFFF);
		send_item(LOAD, 0, 3, 0, 16'hFFFF);
		send_item(LOAD, 0, 0, 3, 16'hFFFF);
		send_item(LOAD, 3, 2, 2, 16'hFFFF);
		send_item(QUERY, 5, 4, 2, 0);
		// A one-pixel source copies the pixel everywhere in the stretch.
		setup_phase(1, 1, 3, 2, 1, 0);
		send_item(QUERY, 2, 1, 0, 0);
		send_item(QUERY, 1, 0, 0, 0);
		// Written zero dimensions read as one; zero destination is all out of range.
		setup_phase(0, 0, 0, 0, 0, 1);
		send_item(QUERY, 0, 0, 0, 0);
		// Fitted height of zero: everything in range is border.
		setup_phase(20, 1, 10, 50, 1, 1);
		send_item(QUERY, 5, 25, 0, 0);
		random_traffic(20);
		// Tall source stretched to a destination that covers every query position.
		setup_phase(2, 40, 1024, 1024, 1, 0);
		random_traffic(40);

		// Random part: mostly small images, varied destinations and modes.
		while (items_sent < 540) begin
			setup_phase($urandom_range(1, 6), $urandom_range(1, 6),
				($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 40),
				($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 40),
				$urandom_range(3), $urandom_range(1));
			random_traffic(40);
		end
		// A fitted height of one on a wide destination.
		setup_phase(8, 3, 1024, 1, 1, 1);
		random_traffic(20);

		drain();
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/lbr_pkg.sv
hdl/lbr_div.sv
hdl/lbr_front.sv
hdl/lbr_back.sv
hdl/letterbox_bilinear_resize.sv
tb/sv/letterbox_bilinear_resize_checker.sv
tb/sv/letterbox_bilinear_resize_tb.sv
